/* design/btnrep_pkg.sv */
// ---------------------------------------------------------------------------
// btnrep_pkg - shared definitions for the button state / typematic unit
// Sizes, operation and register codes, sequencer states and the structs
// passed between the configuration block, the remainder unit and the top.
// ---------------------------------------------------------------------------
`default_nettype none

package btnrep_pkg;

  localparam int BtnCount = 13;
  localparam int CntW     = (BtnCount > 1) ? $clog2(BtnCount) : 1;
  localparam int MaskW    = 13;
  localparam int HeldW    = 16;

  // fixed direction buttons
  localparam int BtnUp    = 0;
  localparam int BtnDown  = 1;
  localparam int BtnLeft  = 2;
  localparam int BtnRight = 3;

  localparam logic [1:0] OpFrame  = 2'd0;
  localparam logic [1:0] OpButton = 2'd1;
  localparam logic [1:0] OpAxis   = 2'd2;

  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic [1:0] RegDeadzone = 2'd0;
  localparam logic [1:0] RegDelay    = 2'd1;
  localparam logic [1:0] RegInterval = 2'd2;

  localparam logic [14:0] DeadzoneRst = 15'd12000;
  localparam logic [15:0] DelayRst    = 16'd420;
  localparam logic [15:0] IntervalRst = 16'd90;

  localparam int DivSteps = HeldW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic [14:0] deadzone;
    logic [15:0] delay;
    logic [15:0] step;      // interval with zero read as one
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StEval = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  function automatic logic [MaskW-1:0] to_mask(input logic [BtnCount-1:0] bits);
    logic [MaskW-1:0] m;
    m = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (i < BtnCount) begin
        m[i] = bits[i];
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* design/btnrep_in_if.sv */
// ---------------------------------------------------------------------------
// btnrep_in_if - input channel of the button state unit
// Valid/ready handshake carrying one event or tick per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface btnrep_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         button_index;
  logic               level;
  logic               axis_select;
  logic signed [15:0] axis_value;
  logic [15:0]        frame_ms;

  modport source (
    output valid, op, button_index, level, axis_select, axis_value, frame_ms,
    input  ready
  );
  modport sink (
    input  valid, op, button_index, level, axis_select, axis_value, frame_ms,
    output ready
  );
endinterface

`default_nettype wire

/* design/btnrep_out_if.sv */
// ---------------------------------------------------------------------------
// btnrep_out_if - result channel of the button state unit
// Valid/ready handshake carrying the four button masks.
// ---------------------------------------------------------------------------
`default_nettype none

interface btnrep_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] down_mask;
  logic [12:0] pressed_mask;
  logic [12:0] released_mask;
  logic [12:0] repeat_mask;

  modport source (
    output valid, down_mask, pressed_mask, released_mask, repeat_mask,
    input  ready
  );
  modport sink (
    input  valid, down_mask, pressed_mask, released_mask, repeat_mask,
    output ready
  );
endinterface

`default_nettype wire

/* design/btnrep_cfg.sv */
// ---------------------------------------------------------------------------
// btnrep_cfg - configuration registers
// APB-style write/read of deadzone, repeat delay and repeat interval.
// ---------------------------------------------------------------------------
`default_nettype none

module btnrep_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [btnrep_pkg::AddrW-1:0] paddr,
  input  wire logic [btnrep_pkg::DataW-1:0] pwdata,
  output logic      [btnrep_pkg::DataW-1:0] prdata,
  output logic                             pready,
  output btnrep_pkg::cfg_t                 cfg_o
);

  logic [14:0] deadzone_q;
  logic [15:0] delay_q;
  logic [15:0] interval_q;
  logic [1:0]  reg_sel;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[btnrep_pkg::AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= btnrep_pkg::DeadzoneRst;
      delay_q    <= btnrep_pkg::DelayRst;
      interval_q <= btnrep_pkg::IntervalRst;
    end else if (wr_en) begin
      unique case (reg_sel)
        btnrep_pkg::RegDeadzone: deadzone_q <= pwdata[14:0];
        btnrep_pkg::RegDelay:    delay_q    <= pwdata[15:0];
        btnrep_pkg::RegInterval: interval_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      btnrep_pkg::RegDeadzone: prdata = {17'd0, deadzone_q};
      btnrep_pkg::RegDelay:    prdata = {16'd0, delay_q};
      btnrep_pkg::RegInterval: prdata = {16'd0, interval_q};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.deadzone = deadzone_q;
  assign cfg_o.delay    = delay_q;
  assign cfg_o.step     = (interval_q == 16'd0) ? 16'd1 : interval_q;

endmodule

`default_nettype wire

/* design/btnrep_rem.sv */
// ---------------------------------------------------------------------------
// btnrep_rem - iterative remainder unit
// Restoring division, one quotient bit per cycle; returns dividend mod
// divisor with a one-cycle done pulse.
// ---------------------------------------------------------------------------
`default_nettype none

module btnrep_rem (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  btnrep_pkg::div_req_t      req_i,
  output btnrep_pkg::div_rsp_t      rsp_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [btnrep_pkg::DivCntW-1:0]   cnt_q;
  logic [15:0]                      rem_q, rem_d;
  logic [15:0]                      dvd_q;
  logic [15:0]                      dsr_q;
  logic [16:0]                      trial;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[15]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = 16'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == btnrep_pkg::DivCntW'(btnrep_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[14:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* design/button_state_with_typematic_repeat_unit.sv */
// ---------------------------------------------------------------------------
// button_state_with_typematic_repeat_unit - button tracker with auto-repeat
// Keeps level, edge flags and held time of the logical buttons and reports
// down, pressed, released and repeat masks after every transaction.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one frame tick, button event or axis sample per transaction;
//   the state update is applied at the accepting edge. out_o then carries
//   exactly one set of masks for that transaction.
//   Repeat is found by a sequencer walking the buttons one at a time; a
//   button that is not down, is below the delay, or whose held time past the
//   delay is below the last frame time is settled without a division, and
//   any other button needs a remainder from the shared bit-serial divider.
//   in_i.ready is low from accept until the result is loaded into the output
//   register, so no new transaction is taken while a scan is running.
//   The result sits in an output register, so a stalled receiver still lets
//   one further transaction be accepted and scanned; the one after that waits
//   until the register drains.
//   Reset clears all button state and loads deadzone 12000, delay 420 ms and
//   interval 90 ms. Configure over the APB port only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module button_state_with_typematic_repeat_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [btnrep_pkg::AddrW-1:0] paddr,
  input  wire logic [btnrep_pkg::DataW-1:0] pwdata,
  output logic      [btnrep_pkg::DataW-1:0] prdata,
  output logic                              pready,
  btnrep_in_if.sink                         in_i,
  btnrep_out_if.source                      out_o
);

  btnrep_pkg::cfg_t     cfg;
  btnrep_pkg::div_req_t div_req;
  btnrep_pkg::div_rsp_t div_rsp;
  btnrep_pkg::state_e   state_q, state_d;

  logic [btnrep_pkg::BtnCount-1:0] level_q, level_d;
  logic [btnrep_pkg::BtnCount-1:0] pressed_q, pressed_d;
  logic [btnrep_pkg::BtnCount-1:0] released_q, released_d;
  logic [15:0]   held_q [btnrep_pkg::BtnCount];
  logic [15:0]   held_d [btnrep_pkg::BtnCount];
  logic [15:0]   last_q, last_d;

  logic [btnrep_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic signed [16:0]              a_q, a_d;
  logic                            dn_q, dn_d;
  logic [btnrep_pkg::BtnCount-1:0] qm_q, qm_d;

  logic        out_valid_q;
  logic [12:0] down_q, press_q, rel_q, rep_q;

  logic                            in_fire;
  logic                            out_load;
  logic [btnrep_pkg::BtnCount-1:0] wr_en;
  logic [btnrep_pkg::BtnCount-1:0] new_lv;
  logic signed [16:0]              val_x, dz_x;
  logic                            neg_on, pos_on;
  logic [16:0]                     sum;
  logic                            rep_bit;
  logic                            advance;
  logic [15:0]                     a_lo;

  btnrep_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  btnrep_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == btnrep_pkg::StIdle);
  assign in_fire    = in_i.valid & in_i.ready;

  // ---- state update for the accepted transaction ----
  assign val_x  = {in_i.axis_value[15], in_i.axis_value};
  assign dz_x   = {2'b00, cfg.deadzone};
  assign neg_on = val_x < -dz_x;
  assign pos_on = val_x > dz_x;

  always_comb begin
    wr_en  = '0;
    new_lv = '0;
    for (int i = 0; i < btnrep_pkg::BtnCount; i++) begin
      if (in_i.op == btnrep_pkg::OpButton) begin
        wr_en[i]  = (int'(in_i.button_index) == i);
        new_lv[i] = in_i.level;
      end else if (in_i.op == btnrep_pkg::OpAxis) begin
        if (!in_i.axis_select) begin
          if (i == btnrep_pkg::BtnLeft) begin
            wr_en[i]  = 1'b1;
            new_lv[i] = neg_on;
          end else if (i == btnrep_pkg::BtnRight) begin
            wr_en[i]  = 1'b1;
            new_lv[i] = pos_on;
          end
        end else begin
          if (i == btnrep_pkg::BtnUp) begin
            wr_en[i]  = 1'b1;
            new_lv[i] = neg_on;
          end else if (i == btnrep_pkg::BtnDown) begin
            wr_en[i]  = 1'b1;
            new_lv[i] = pos_on;
          end
        end
      end
    end
  end

  always_comb begin
    level_d    = level_q;
    pressed_d  = pressed_q;
    released_d = released_q;
    held_d     = held_q;
    last_d     = last_q;
    sum        = '0;
    if (in_fire) begin
      if (in_i.op == btnrep_pkg::OpFrame) begin
        last_d     = in_i.frame_ms;
        pressed_d  = '0;
        released_d = '0;
        for (int i = 0; i < btnrep_pkg::BtnCount; i++) begin
          sum = {1'b0, held_q[i]} + {1'b0, in_i.frame_ms};
          if (level_q[i]) begin
            held_d[i] = sum[16] ? 16'hFFFF : sum[15:0];
          end
        end
      end else begin
        for (int i = 0; i < btnrep_pkg::BtnCount; i++) begin
          if (wr_en[i] && (level_q[i] != new_lv[i])) begin
            level_d[i]    = new_lv[i];
            pressed_d[i]  = new_lv[i];
            released_d[i] = ~new_lv[i];
            if (new_lv[i]) begin
              held_d[i] = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      pressed_q  <= '0;
      released_q <= '0;
      last_q     <= '0;
      for (int i = 0; i < btnrep_pkg::BtnCount; i++) begin
        held_q[i] <= '0;
      end
    end else begin
      level_q    <= level_d;
      pressed_q  <= pressed_d;
      released_q <= released_d;
      last_q     <= last_d;
      held_q     <= held_d;
    end
  end

  // ---- repeat scan sequencer ----
  // a = held - delay. With a >= last the step changes iff last > a mod step;
  // otherwise both truncated quotients are zero unless a or last - a reach
  // a full step.
  assign a_lo    = a_q[15:0];
  assign out_load = (state_q == btnrep_pkg::StDone) & (~out_valid_q | out_o.ready);

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    a_d              = a_q;
    dn_d             = dn_q;
    qm_d             = qm_q;
    rep_bit          = 1'b0;
    advance          = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = a_lo;
    div_req.divisor  = cfg.step;
    unique case (state_q)
      btnrep_pkg::StIdle: begin
        if (in_fire) begin
          cnt_d   = '0;
          qm_d    = '0;
          state_d = btnrep_pkg::StScan;
        end
      end
      btnrep_pkg::StScan: begin
        a_d     = $signed({1'b0, held_q[cnt_q]}) - $signed({1'b0, cfg.delay});
        dn_d    = level_q[cnt_q];
        state_d = btnrep_pkg::StEval;
      end
      btnrep_pkg::StEval: begin
        if (!dn_q || a_q[16]) begin
          advance = 1'b1;
        end else if (last_q > a_lo) begin
          rep_bit = (a_lo >= cfg.step) || (16'(last_q - a_lo) >= cfg.step);
          advance = 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_d       = btnrep_pkg::StDiv;
        end
      end
      btnrep_pkg::StDiv: begin
        if (div_rsp.done) begin
          rep_bit = last_q > div_rsp.rem;
          advance = 1'b1;
        end
      end
      btnrep_pkg::StDone: begin
        if (out_load) begin
          state_d = btnrep_pkg::StIdle;
        end
      end
      default: state_d = btnrep_pkg::StIdle;
    endcase
    if (advance) begin
      qm_d[cnt_q] = rep_bit;
      if (cnt_q == btnrep_pkg::CntW'(btnrep_pkg::BtnCount - 1)) begin
        state_d = btnrep_pkg::StDone;
      end else begin
        cnt_d   = cnt_q + 1'b1;
        state_d = btnrep_pkg::StScan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btnrep_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    dn_q <= dn_d;
    qm_q <= qm_d;
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      down_q  <= btnrep_pkg::to_mask(level_q);
      press_q <= btnrep_pkg::to_mask(pressed_q);
      rel_q   <= btnrep_pkg::to_mask(released_q);
      rep_q   <= btnrep_pkg::to_mask(qm_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.down_mask     = down_q;
  assign out_o.pressed_mask  = press_q;
  assign out_o.released_mask = rel_q;
  assign out_o.repeat_mask   = rep_q;

  // ---- assertions ----
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input accepted again directly after a transaction");

  a_repeat_needs_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.repeat_mask & ~out_o.down_mask) == 13'd0))
    else $error("repeat reported for a button that is up");

  a_edges_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pressed_q & released_q) == '0)
    else $error("button flagged pressed and released together");

  a_div_only_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (state_q == btnrep_pkg::StDiv))
    else $error("remainder started outside the evaluation step");

endmodule

`default_nettype wire
